// File: src/mandelbrot_escape_time_macros.svh
// Assertion helpers shared by the RTL. They expect clk and arst_n in scope.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MET_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define MET_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: src/mandel_pkg.sv
package mandel_pkg;

	localparam int COORD_W = 32;
	localparam int ITER_W  = 16;
	localparam int PIX_W   = 9;
	localparam int FRAC_W  = 26;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 24;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam int MEP_IMAGE_WIDTH  = 512;
	localparam int MEP_IMAGE_HEIGHT = 512;

	// Register indexes on the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_X_MIN    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_X_MAX    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_Y_MIN    = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_Y_MAX    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER = 3'd4;

	// Reset values: region -2.0 .. 1.0 by -1.5 .. 1.5, limit 250.
	localparam logic signed [COORD_W-1:0] X_MIN_RST = -32'sd134217728;
	localparam logic signed [COORD_W-1:0] X_MAX_RST = 32'sd67108864;
	localparam logic signed [COORD_W-1:0] Y_MIN_RST = -32'sd100663296;
	localparam logic signed [COORD_W-1:0] Y_MAX_RST = 32'sd100663296;
	localparam logic [ITER_W-1:0]         MAX_ITER_RST = 16'd250;

	// Floor of log2, so an image size that is not a power of two rounds down.
	function automatic int log2_floor(input int n);
		int s;
		int v;
		s = 0;
		v = n;
		while (v > 1 && s < 31) begin
			v = v >> 1;
			s = s + 1;
		end
		return s;
	endfunction

endpackage

// File: src/mandelbrot_escape_time.sv
// Mandelbrot escape-time engine. A pixel (pixel_x, pixel_y) is taken only while
// the engine is idle; it is mapped into the configured region and the orbit
// z = z*z + c is run from zero until |z|^2 exceeds 4.0 or max_iterations steps
// are done. One 33x33 signed multiplier is shared by all work: the states MAPX
// and MAPY map the pixel, MAPC finishes the point, each iteration runs SQR, SQI,
// CROSS (three products) and UPD (the update), and the last escape check runs
// SQR, SQI and CROSS before FIN hands the result off. The result sits in an
// output register, so the next pixel can be accepted while it waits to be
// taken. Coordinates are signed Q6.26.
`include "mandelbrot_escape_time_macros.svh"

module mandelbrot_escape_time #(
	parameter int IMAGE_WIDTH  = mandel_pkg::MEP_IMAGE_WIDTH,
	parameter int IMAGE_HEIGHT = mandel_pkg::MEP_IMAGE_HEIGHT
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [mandel_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [mandel_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [8:0] pixel_x, [17:9] pixel_y, [23:18] zero
	input  logic [mandel_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [15:0] iterations, [16] escaped, [23:17] zero
	output logic [mandel_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import mandel_pkg::*;

	localparam int SHIFT_X = log2_floor(IMAGE_WIDTH);
	localparam int SHIFT_Y = log2_floor(IMAGE_HEIGHT);
	localparam int MUL_W   = COORD_W + 1;
	localparam int PROD_W  = 2 * COORD_W;
	localparam int MAP_W   = PIX_W + MUL_W + 1;
	localparam logic [PROD_W:0] LIMIT4 = (PROD_W+1)'(1) << (2 * FRAC_W + 2);

	typedef enum logic [3:0] {
		ST_IDLE, ST_MAPX, ST_MAPY, ST_MAPC, ST_SQR, ST_SQI, ST_CROSS, ST_UPD, ST_FIN
	} state_t;

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic signed [PROD_W-1:0] hi;
		logic signed [PROD_W-1:0] lo;
		hi = PROD_W'(2147483647);
		lo = -(PROD_W'(2147483647)) - PROD_W'(1);
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	state_t state_q;

	logic signed [COORD_W-1:0] x_min_q, x_max_q, y_min_q, y_max_q;
	logic [ITER_W-1:0]         max_iter_q;

	logic [PIX_W-1:0]          px_q, py_q;
	logic signed [COORD_W-1:0] c_real_q, c_imag_q, z_real_q, z_imag_q;
	logic [ITER_W-1:0]         count_q;
	logic signed [PROD_W-1:0]  prod_q, rr_q;
	logic [ITER_W-1:0]         pend_iter_q;
	logic                      pend_esc_q;
	logic                      out_valid_q;
	logic [ITER_W-1:0]         out_iter_q;
	logic                      out_esc_q;

	logic signed [MUL_W-1:0]   dx, dy, mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;
	logic signed [MAP_W-1:0]   map_prod;
	logic signed [PROD_W-1:0]  map_x_sum, map_y_sum;
	logic signed [PROD_W-1:0]  next_re, next_im, sq_diff;
	logic [PROD_W:0]           mag_sq;
	logic                      escape;
	logic                      in_accept, out_free;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign out_free  = !out_valid_q || m_axis_tready;

	assign dx = MUL_W'(x_max_q) - MUL_W'(x_min_q);
	assign dy = MUL_W'(y_max_q) - MUL_W'(y_min_q);

	// Operand select for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_MAPX: begin
				mul_a = $signed({{(MUL_W-PIX_W){1'b0}}, px_q});
				mul_b = dx;
			end
			ST_MAPY: begin
				mul_a = $signed({{(MUL_W-PIX_W){1'b0}}, py_q});
				mul_b = dy;
			end
			ST_SQR: begin
				mul_a = MUL_W'(z_real_q);
				mul_b = MUL_W'(z_real_q);
			end
			ST_SQI: begin
				mul_a = MUL_W'(z_imag_q);
				mul_b = MUL_W'(z_imag_q);
			end
			ST_CROSS: begin
				mul_a = MUL_W'(z_real_q);
				mul_b = MUL_W'(z_imag_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// The mapping products fit in MAP_W bits; the shift is the divide by image size.
	assign map_prod  = prod_q[MAP_W-1:0];
	assign map_x_sum = PROD_W'(map_prod >>> SHIFT_X) + PROD_W'(x_min_q);
	assign map_y_sum = PROD_W'(map_prod >>> SHIFT_Y) + PROD_W'(y_min_q);

	// In the update cycle prod_q holds zr*zi; doubling it is one less bit of shift.
	assign sq_diff = rr_q - prod_q;
	assign next_re = (rr_q >>> FRAC_W) + PROD_W'(c_real_q);
	assign next_im = (prod_q >>> (FRAC_W - 1)) + PROD_W'(c_imag_q);

	// In the cross cycle rr_q holds zr^2 and prod_q holds zi^2, both nonnegative.
	assign mag_sq = {1'b0, rr_q} + {1'b0, prod_q};
	assign escape = mag_sq > LIMIT4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q    <= X_MIN_RST;
			x_max_q    <= X_MAX_RST;
			y_min_q    <= Y_MIN_RST;
			y_max_q    <= Y_MAX_RST;
			max_iter_q <= MAX_ITER_RST;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				REG_X_MIN:    x_min_q    <= cfg_wdata;
				REG_X_MAX:    x_max_q    <= cfg_wdata;
				REG_Y_MIN:    y_min_q    <= cfg_wdata;
				REG_Y_MAX:    y_max_q    <= cfg_wdata;
				REG_MAX_ITER: max_iter_q <= cfg_wdata[ITER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		prod_q <= mul_p[PROD_W-1:0];
		if (in_accept) begin
			px_q <= s_axis_tdata[PIX_W-1:0];
			py_q <= s_axis_tdata[2*PIX_W-1:PIX_W];
		end
		case (state_q)
			ST_MAPY: c_real_q <= sat32(map_x_sum);
			ST_MAPC: begin
				c_imag_q <= sat32(map_y_sum);
				z_real_q <= '0;
				z_imag_q <= '0;
				count_q  <= '0;
			end
			ST_SQI: rr_q <= prod_q;
			ST_CROSS: begin
				rr_q        <= sq_diff;
				pend_iter_q <= count_q;
				pend_esc_q  <= escape && (count_q < max_iter_q);
			end
			ST_UPD: begin
				z_real_q <= sat32(next_re);
				z_imag_q <= sat32(next_im);
				count_q  <= count_q + ITER_W'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_iter_q  <= '0;
			out_esc_q   <= 1'b0;
		end else begin
			// A finished pixel refills the output register in the cycle it drains.
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
				out_iter_q  <= pend_iter_q;
				out_esc_q   <= pend_esc_q;
			end else if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE:  if (s_axis_tvalid) state_q <= ST_MAPX;
				ST_MAPX:  state_q <= ST_MAPY;
				ST_MAPY:  state_q <= ST_MAPC;
				ST_MAPC:  state_q <= ST_SQR;
				ST_SQR:   state_q <= ST_SQI;
				ST_SQI:   state_q <= ST_CROSS;
				ST_CROSS: begin
					if (escape || count_q >= max_iter_q) begin
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD:   state_q <= ST_SQR;
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(OUT_TDATA_W-ITER_W-1){1'b0}}, out_esc_q, out_iter_q};

	// The orbit starts at zero, so no point can escape before its first step.
	`MET_ASSERT_SAME(a_esc_nonzero, out_valid_q && out_esc_q, out_iter_q != '0)
	`MET_ASSERT_NEXT(a_accept_maps, in_accept, state_q == ST_MAPX)
	`MET_ASSERT_NEXT(a_fin_delivers, state_q == ST_FIN && out_free, m_axis_tvalid && state_q == ST_IDLE)
	`MET_ASSERT_SAME(a_sqr_entry, state_q == ST_SQR, $past(state_q) == ST_UPD || $past(state_q) == ST_MAPC)

endmodule
